// ----- src/ldm_pkg.sv -----
// ----------------------------------------------------------------------------
// ldm_pkg: shared types and constants of the lock drop monitor
// Word layouts for the poll and report channels, register map and defaults.
// ----------------------------------------------------------------------------
package ldm_pkg;

	localparam int TIME_W          = 64;
	localparam int OUT_CNT_W       = 32;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int PADDR_W         = 4;
	localparam int PDATA_W         = 64;
	localparam int REG_IDX_W       = PADDR_W - 3;

	localparam logic [REG_IDX_W-1:0] REG_MERGE_TIME = REG_IDX_W'(0);

	localparam logic ACT_INIT = 1'b0;
	localparam logic ACT_POLL = 1'b1;

	typedef struct packed {
		logic              action;
		logic [TIME_W-1:0] now_time;
		logic              lock_flag;
		logic              hold_flag;
		logic              count_enable;
	} poll_t;

	typedef struct packed {
		logic                 locked_now;
		logic [TIME_W-1:0]    state_since;
		logic [TIME_W-1:0]    servo_since;
		logic [OUT_CNT_W-1:0] drop_count;
		logic [OUT_CNT_W-1:0] edge_count;
		logic [TIME_W-1:0]    unlocked_total;
		logic [TIME_W-1:0]    last_drop_length;
		logic [TIME_W-1:0]    longest_since_servo;
		logic                 event_valid;
		logic [OUT_CNT_W-1:0] event_index;
		logic [TIME_W-1:0]    event_start;
		logic [TIME_W-1:0]    event_duration;
	} report_t;

endpackage

// ----- src/ldm_if.sv -----
// ----------------------------------------------------------------------------
// ldm_poll_if / ldm_report_if: valid/ready channels of the lock drop monitor
// One word per handshake; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ldm_poll_if;
	import ldm_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [TIME_W-1:0] now_time;
	logic              lock_flag;
	logic              hold_flag;
	logic              count_enable;

	modport source (output valid, action, now_time, lock_flag, hold_flag, count_enable,
		input ready);
	modport sink (input valid, action, now_time, lock_flag, hold_flag, count_enable,
		output ready);
endinterface

interface ldm_report_if;
	import ldm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 locked_now;
	logic [TIME_W-1:0]    state_since;
	logic [TIME_W-1:0]    servo_since;
	logic [OUT_CNT_W-1:0] drop_count;
	logic [OUT_CNT_W-1:0] edge_count;
	logic [TIME_W-1:0]    unlocked_total;
	logic [TIME_W-1:0]    last_drop_length;
	logic [TIME_W-1:0]    longest_since_servo;
	logic                 event_valid;
	logic [OUT_CNT_W-1:0] event_index;
	logic [TIME_W-1:0]    event_start;
	logic [TIME_W-1:0]    event_duration;

	modport source (output valid, locked_now, state_since, servo_since, drop_count,
		edge_count, unlocked_total, last_drop_length, longest_since_servo, event_valid,
		event_index, event_start, event_duration, input ready);
	modport sink (input valid, locked_now, state_since, servo_since, drop_count,
		edge_count, unlocked_total, last_drop_length, longest_since_servo, event_valid,
		event_index, event_start, event_duration, output ready);
endinterface

// ----- src/ldm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ldm_cfg_regs: APB register file of the lock drop monitor
// Holds the merge time; writes complete in the access cycle, reads are direct.
// ----------------------------------------------------------------------------
module ldm_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ldm_pkg::PADDR_W-1:0]   paddr,
	input  logic [ldm_pkg::PDATA_W-1:0]   pwdata,
	output logic [ldm_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [ldm_pkg::TIME_W-1:0]    merge_time
);
	import ldm_pkg::*;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	logic [TIME_W-1:0]    merge_time_q;

	assign reg_idx = paddr[PADDR_W-1:3];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_time_q <= '0;
		end else if (wr_en && (reg_idx == REG_MERGE_TIME)) begin
			merge_time_q <= pwdata;
		end
	end

	assign prdata     = (reg_idx == REG_MERGE_TIME) ? merge_time_q : '0;
	assign merge_time = merge_time_q;
endmodule

// ----- src/ldm_core.sv -----
// ----------------------------------------------------------------------------
// ldm_core: drop tracking state and its single-pass update
// Computes the next state and the report word for the staged poll word and
// commits the state when the word moves on to the output register.
// ----------------------------------------------------------------------------
module ldm_core #(
	parameter int COUNT_WIDTH = ldm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  ldm_pkg::poll_t             item,
	input  logic [ldm_pkg::TIME_W-1:0] merge_time,
	output ldm_pkg::report_t           report
);
	import ldm_pkg::*;

	localparam int EXT_W = 64;

	logic                   prev_raw_q, prev_hold_q, lock_q, active_q, streak_valid_q;
	logic [TIME_W-1:0]      sct_q, servo_q, streak_q, tb_q, ds_q, total_q, last_q, longest_q;
	logic [COUNT_WIDTH-1:0] opened_q, edges_q, closed_q;

	logic                   n_prev_raw, n_prev_hold, n_lock, n_active, n_streak_valid;
	logic [TIME_W-1:0]      n_sct, n_servo, n_streak, n_tb, n_ds, n_total, n_last, n_longest;
	logic [COUNT_WIDTH-1:0] n_opened, n_edges, n_closed;

	logic              now_poll, lk, hd, pr;
	logic [TIME_W-1:0] now;
	logic              hold_rise, hold_fall, rise_raw, fall_raw;
	logic [TIME_W-1:0] streak_s, elapsed;
	logic              streak_v, merge_hit, fin;
	logic [TIME_W-1:0] dur_now, dur_str, dur, tot_now, tot_str, longest_base, fin_end;
	logic              ev_valid;
	logic [EXT_W-1:0]  opened_ext, edges_ext, closed_ext;

	assign now_poll = (item.action == ACT_POLL);
	assign now      = item.now_time;
	assign lk       = item.lock_flag;
	assign hd       = item.hold_flag;
	assign pr       = prev_raw_q;

	assign hold_rise = hd && !prev_hold_q;
	assign hold_fall = !hd && prev_hold_q;
	assign rise_raw  = !pr && lk;
	assign fall_raw  = pr && !lk;

	assign streak_s  = rise_raw ? now : streak_q;
	assign streak_v  = rise_raw || streak_valid_q;
	assign elapsed   = now - streak_s;
	assign merge_hit = active_q && !hd && lk && streak_v && (elapsed >= merge_time);
	assign fin       = now_poll && ((hold_rise && active_q) || merge_hit);

	assign dur_now      = now - ds_q;
	assign dur_str      = streak_s - ds_q;
	assign tot_now      = tb_q + dur_now;
	assign tot_str      = tb_q + dur_str;
	assign dur          = merge_hit ? dur_str : dur_now;
	assign fin_end      = merge_hit ? streak_s : now;
	assign longest_base = hold_fall ? '0 : longest_q;

	always_comb begin
		n_prev_raw     = lk;
		n_prev_hold    = hd;
		n_lock         = lock_q;
		n_active       = active_q;
		n_streak_valid = streak_valid_q;
		n_sct          = sct_q;
		n_servo        = servo_q;
		n_streak       = streak_q;
		n_tb           = tb_q;
		n_ds           = ds_q;
		n_total        = total_q;
		n_last         = last_q;
		n_longest      = longest_q;
		n_opened       = opened_q;
		n_edges        = edges_q;
		n_closed       = closed_q;
		ev_valid       = 1'b0;

		if (!now_poll) begin
			n_lock         = lk;
			n_active       = 1'b0;
			n_streak_valid = 1'b0;
			n_sct          = now;
			n_servo        = hd ? '0 : now;
			n_tb           = '0;
			n_ds           = '0;
			n_total        = '0;
			n_last         = '0;
			n_longest      = '0;
			n_opened       = '0;
			n_edges        = '0;
			n_closed       = '0;
		end else begin
			if (hold_rise) begin
				n_servo = '0;
			end else if (hold_fall) begin
				n_servo = now;
			end
			n_longest = longest_base;

			if (fin) begin
				n_active       = 1'b0;
				n_streak_valid = 1'b0;
				n_total        = merge_hit ? tot_str : tot_now;
				n_last         = dur;
				if (dur > longest_base) begin
					n_longest = dur;
				end
				n_closed = closed_q + COUNT_WIDTH'(1);
				ev_valid = 1'b1;
				n_lock   = 1'b1;
				n_sct    = fin_end;
			end

			if (hd) begin
				if (lk != n_lock) begin
					n_lock = lk;
					n_sct  = now;
				end
			end else if (!active_q) begin
				if (fall_raw) begin
					if (item.count_enable) begin
						n_active       = 1'b1;
						n_streak_valid = 1'b0;
						n_tb           = total_q;
						n_ds           = now;
						n_opened       = opened_q + COUNT_WIDTH'(1);
						n_edges        = edges_q + COUNT_WIDTH'(1);
					end
					n_lock = 1'b0;
					n_sct  = now;
				end else if (rise_raw) begin
					n_lock = 1'b1;
					n_sct  = now;
				end
			end else if (lk) begin
				if (!merge_hit) begin
					n_streak       = streak_s;
					n_streak_valid = streak_v;
					n_total        = tot_now;
				end
			end else begin
				if (pr) begin
					n_edges = edges_q + COUNT_WIDTH'(1);
				end
				n_streak_valid = 1'b0;
				n_total        = tot_now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q     <= 1'b0;
			prev_hold_q    <= 1'b0;
			lock_q         <= 1'b0;
			active_q       <= 1'b0;
			streak_valid_q <= 1'b0;
			sct_q          <= '0;
			servo_q        <= '0;
			tb_q           <= '0;
			ds_q           <= '0;
			total_q        <= '0;
			last_q         <= '0;
			longest_q      <= '0;
			opened_q       <= '0;
			edges_q        <= '0;
			closed_q       <= '0;
		end else if (advance) begin
			prev_raw_q     <= n_prev_raw;
			prev_hold_q    <= n_prev_hold;
			lock_q         <= n_lock;
			active_q       <= n_active;
			streak_valid_q <= n_streak_valid;
			sct_q          <= n_sct;
			servo_q        <= n_servo;
			tb_q           <= n_tb;
			ds_q           <= n_ds;
			total_q        <= n_total;
			last_q         <= n_last;
			longest_q      <= n_longest;
			opened_q       <= n_opened;
			edges_q        <= n_edges;
			closed_q       <= n_closed;
		end
	end

	// The streak start is only read while its valid bit is set.
	always_ff @(posedge clk) begin
		if (advance) begin
			streak_q <= n_streak;
		end
	end

	assign opened_ext = EXT_W'(n_opened);
	assign edges_ext  = EXT_W'(n_edges);
	assign closed_ext = EXT_W'(n_closed);

	always_comb begin
		report.locked_now          = n_lock;
		report.state_since         = n_sct;
		report.servo_since         = n_servo;
		report.drop_count          = opened_ext[OUT_CNT_W-1:0];
		report.edge_count          = edges_ext[OUT_CNT_W-1:0];
		report.unlocked_total      = n_total;
		report.last_drop_length    = n_last;
		report.longest_since_servo = n_longest;
		report.event_valid         = ev_valid;
		report.event_index         = ev_valid ? closed_ext[OUT_CNT_W-1:0] : '0;
		report.event_start         = ev_valid ? ds_q : '0;
		report.event_duration      = ev_valid ? dur : '0;
	end
endmodule

// ----- src/lock_drop_monitor.sv -----
// ----------------------------------------------------------------------------
// lock_drop_monitor: lock drop statistics of a servo controller
// Path: a poll word accepted is staged in item_s1, and its report word is
//   registered in rep_q when the output register is empty or being read.
// Throughput: one word per cycle unless reports stall; one-pass state update.
// Reset: arst_n clears all statistics, the flags and the merge time at once.
// ----------------------------------------------------------------------------
module lock_drop_monitor #(
	parameter int COUNT_WIDTH = ldm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ldm_poll_if.sink                    polls,
	ldm_report_if.source                reports,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ldm_pkg::PADDR_W-1:0] paddr,
	input  logic [ldm_pkg::PDATA_W-1:0] pwdata,
	output logic [ldm_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import ldm_pkg::*;

	logic              valid_s1;
	poll_t             item_s1;
	logic              out_valid_q;
	report_t           rep_q;
	report_t           report;
	logic              advance;
	logic [TIME_W-1:0] merge_time;

	ldm_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.merge_time (merge_time)
	);

	assign advance      = valid_s1 && (!out_valid_q || reports.ready);
	assign polls.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (polls.valid && polls.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (polls.valid && polls.ready) begin
			item_s1.action       <= polls.action;
			item_s1.now_time     <= polls.now_time;
			item_s1.lock_flag    <= polls.lock_flag;
			item_s1.hold_flag    <= polls.hold_flag;
			item_s1.count_enable <= polls.count_enable;
		end
	end

	ldm_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.merge_time (merge_time),
		.report     (report)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (reports.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rep_q <= report;
		end
	end

	assign reports.valid               = out_valid_q;
	assign reports.locked_now          = rep_q.locked_now;
	assign reports.state_since         = rep_q.state_since;
	assign reports.servo_since         = rep_q.servo_since;
	assign reports.drop_count          = rep_q.drop_count;
	assign reports.edge_count          = rep_q.edge_count;
	assign reports.unlocked_total      = rep_q.unlocked_total;
	assign reports.last_drop_length    = rep_q.last_drop_length;
	assign reports.longest_since_servo = rep_q.longest_since_servo;
	assign reports.event_valid         = rep_q.event_valid;
	assign reports.event_index         = rep_q.event_index;
	assign reports.event_start         = rep_q.event_start;
	assign reports.event_duration      = rep_q.event_duration;

	// A staged word that can move must land in the output register.
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("staged word was lost");

	// An empty input stage never stalls the poll channel.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> polls.ready)
		else $error("input stage empty but not ready");

	// Event fields are zero whenever no drop closed.
	a_event_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rep_q.event_valid) |-> (rep_q.event_index == '0 &&
		rep_q.event_start == '0 && rep_q.event_duration == '0))
		else $error("event fields set without an event");
endmodule

// ----- tb/sv/ldm_report_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldm_report_checker: scoreboard of the lock drop monitor
// Watches the poll and report channels and the register port. For every poll
// word taken by the block it computes the report word the block has to send,
// keeps it in order and compares each report word with it field by field.
// ----------------------------------------------------------------------------
module ldm_report_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	ldm_poll_if                         polls,
	ldm_report_if                       reports,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ldm_pkg::PADDR_W-1:0] paddr,
	input  logic [ldm_pkg::PDATA_W-1:0] pwdata,
	input  logic                        pready,
	output int                          fail_count,
	output int                          pending,
	output int                          word_count,
	output int                          event_count
);
	import ldm_pkg::*;

	logic [TIME_W-1:0]    merge_len;
	logic                 raw_q, hold_q, locked, drop_live, streak_ok;
	logic [TIME_W-1:0]    change_t, servo_t, streak_t, total_before, drop_t, total_unl;
	logic [TIME_W-1:0]    last_len, longest;
	logic [OUT_CNT_W-1:0] opened, edges, closed;
	logic                 ev_valid;
	logic [OUT_CNT_W-1:0] ev_index;
	logic [TIME_W-1:0]    ev_start, ev_len;

	report_t reports_due[$];

	function automatic void clear_history();
		raw_q = 1'b0;
		hold_q = 1'b0;
		locked = 1'b0;
		drop_live = 1'b0;
		streak_ok = 1'b0;
		change_t = '0;
		servo_t = '0;
		streak_t = '0;
		total_before = '0;
		drop_t = '0;
		total_unl = '0;
		last_len = '0;
		longest = '0;
		opened = '0;
		edges = '0;
		closed = '0;
	endfunction

	function automatic void end_drop(input logic [TIME_W-1:0] end_t);
		logic [TIME_W-1:0] len;
		len = end_t - drop_t;
		drop_live = 1'b0;
		streak_ok = 1'b0;
		streak_t = '0;
		total_unl = total_before + len;
		last_len = len;
		if (len > longest) begin
			longest = len;
		end
		closed = closed + 1'b1;
		ev_valid = 1'b1;
		ev_index = closed;
		ev_start = drop_t;
		ev_len = len;
		locked = 1'b1;
		change_t = end_t;
	endfunction

	function automatic report_t next_report(input poll_t w);
		report_t r;
		logic pr, ph, shut;
		ev_valid = 1'b0;
		ev_index = '0;
		ev_start = '0;
		ev_len = '0;
		if (w.action == ACT_INIT) begin
			clear_history();
			locked = w.lock_flag;
			raw_q = w.lock_flag;
			hold_q = w.hold_flag;
			change_t = w.now_time;
			servo_t = w.hold_flag ? '0 : w.now_time;
		end else begin
			pr = raw_q;
			ph = hold_q;
			raw_q = w.lock_flag;
			hold_q = w.hold_flag;
			if (w.hold_flag && !ph) begin
				if (drop_live) begin
					end_drop(w.now_time);
				end
				servo_t = '0;
			end else if (!w.hold_flag && ph) begin
				servo_t = w.now_time;
				longest = '0;
			end
			if (w.hold_flag) begin
				if (w.lock_flag != locked) begin
					locked = w.lock_flag;
					change_t = w.now_time;
				end
			end else if (!drop_live) begin
				if (pr && !w.lock_flag) begin
					if (w.count_enable) begin
						drop_live = 1'b1;
						streak_ok = 1'b0;
						streak_t = '0;
						total_before = total_unl;
						drop_t = w.now_time;
						opened = opened + 1'b1;
						edges = edges + 1'b1;
					end
					locked = 1'b0;
					change_t = w.now_time;
				end else if (!pr && w.lock_flag) begin
					locked = 1'b1;
					change_t = w.now_time;
				end
			end else begin
				shut = 1'b0;
				if (w.lock_flag) begin
					if (!pr) begin
						streak_t = w.now_time;
						streak_ok = 1'b1;
					end
					if (streak_ok && w.now_time - streak_t >= merge_len) begin
						end_drop(streak_t);
						shut = 1'b1;
					end
				end else begin
					if (pr) begin
						edges = edges + 1'b1;
					end
					streak_ok = 1'b0;
					streak_t = '0;
				end
				if (!shut) begin
					total_unl = total_before + (w.now_time - drop_t);
				end
			end
		end
		r.locked_now = locked;
		r.state_since = change_t;
		r.servo_since = servo_t;
		r.drop_count = opened;
		r.edge_count = edges;
		r.unlocked_total = total_unl;
		r.last_drop_length = last_len;
		r.longest_since_servo = longest;
		r.event_valid = ev_valid;
		r.event_index = ev_index;
		r.event_start = ev_start;
		r.event_duration = ev_len;
		return r;
	endfunction

	function automatic int field_diff(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		report_t seen, want;
		if (!arst_n) begin
			clear_history();
			merge_len = '0;
			reports_due.delete();
			fail_count = 0;
			pending = 0;
			word_count = 0;
			event_count = 0;
		end else begin
			if (reports.valid && reports.ready) begin
				seen = {reports.locked_now, reports.state_since, reports.servo_since,
					reports.drop_count, reports.edge_count, reports.unlocked_total,
					reports.last_drop_length, reports.longest_since_servo,
					reports.event_valid, reports.event_index, reports.event_start,
					reports.event_duration};
				word_count++;
				if (reports_due.size() == 0) begin
					$display("%0t: report word expected none actual state_since %0h",
						$time, seen.state_since);
					fail_count++;
				end else begin
					want = reports_due.pop_front();
					if (want.event_valid) begin
						event_count++;
					end
					fail_count += field_diff("locked_now", want.locked_now, seen.locked_now)
						+ field_diff("state_since", want.state_since, seen.state_since)
						+ field_diff("servo_since", want.servo_since, seen.servo_since)
						+ field_diff("drop_count", want.drop_count, seen.drop_count)
						+ field_diff("edge_count", want.edge_count, seen.edge_count)
						+ field_diff("unlocked_total", want.unlocked_total,
							seen.unlocked_total)
						+ field_diff("last_drop_length", want.last_drop_length,
							seen.last_drop_length)
						+ field_diff("longest_since_servo", want.longest_since_servo,
							seen.longest_since_servo)
						+ field_diff("event_valid", want.event_valid, seen.event_valid)
						+ field_diff("event_index", want.event_index, seen.event_index)
						+ field_diff("event_start", want.event_start, seen.event_start)
						+ field_diff("event_duration", want.event_duration,
							seen.event_duration);
				end
			end
			if (psel && penable && pwrite && pready
				&& paddr == {REG_MERGE_TIME, 3'b000}) begin
				merge_len = pwdata;
			end
			if (polls.valid && polls.ready) begin
				reports_due.push_back(next_report({polls.action, polls.now_time,
					polls.lock_flag, polls.hold_flag, polls.count_enable}));
			end
			pending = reports_due.size();
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench of the lock drop monitor
// Drives init and poll words and merge time writes into the block, with random
// gaps on both channels and one long receiver hold-off, and leaves prediction
// and comparison of every report word to the checker beside the block.
// ----------------------------------------------------------------------------
module tb;
	import ldm_pkg::*;

	localparam int LONG_HOLD   = 300;
	localparam int STALL_LIMIT = 3000;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int fail_count, pending, word_count, event_count;
	int idle_cycles;
	bit sender_idle, sink_idle, stall_go, stall_done;

	logic [TIME_W-1:0] stamp;
	logic              lk_cur, hd_cur;

	ldm_poll_if   polls_if();
	ldm_report_if reports_if();

	lock_drop_monitor u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.polls   (polls_if),
		.reports (reports_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	ldm_report_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.polls       (polls_if),
		.reports     (reports_if),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.fail_count  (fail_count),
		.pending     (pending),
		.word_count  (word_count),
		.event_count (event_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (polls_if.valid && polls_if.ready)
			|| (reports_if.valid && reports_if.ready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		reports_if.ready = 1'b0;
		stall_done = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_go && !stall_done) begin
				reports_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				stall_done = 1'b1;
			end
			reports_if.ready <= !(sink_idle && $urandom_range(0, 99) < 28);
		end
	end

	task automatic send_word(input logic act, input logic [TIME_W-1:0] t,
		input logic lk, input logic hd, input logic ce);
		while (sender_idle && $urandom_range(0, 99) < 28) begin
			polls_if.valid <= 1'b0;
			@(negedge clk);
		end
		polls_if.valid <= 1'b1;
		polls_if.action <= act;
		polls_if.now_time <= t;
		polls_if.lock_flag <= lk;
		polls_if.hold_flag <= hd;
		polls_if.count_enable <= ce;
		do @(posedge clk); while (!polls_if.ready);
		@(negedge clk);
	endtask

	task automatic set_merge(input logic [TIME_W-1:0] value);
		polls_if.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {REG_MERGE_TIME, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_run(input int count, input int step_max, input int stall_at);
		int roll;
		logic act;
		for (int i = 0; i < count; i++) begin
			if (i == stall_at) begin
				stall_go = 1'b1;
			end
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send_word(1'($urandom_range(0, 1)), {$urandom, $urandom},
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end else begin
				if (roll < 10) begin
					stamp = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 300));
				end else if (roll < 12) begin
					stamp = stamp + {$urandom, $urandom};
				end else begin
					stamp = stamp + 64'($urandom_range(0, step_max));
				end
				if ($urandom_range(0, 99) < 30) begin
					lk_cur = ~lk_cur;
				end
				if ($urandom_range(0, 99) < 4) begin
					hd_cur = ~hd_cur;
				end
				act = ($urandom_range(0, 99) < 2) ? ACT_INIT : ACT_POLL;
				send_word(act, stamp, lk_cur, hd_cur, $urandom_range(0, 99) < 85);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		polls_if.valid = 1'b0;
		polls_if.action = ACT_POLL;
		polls_if.now_time = '0;
		polls_if.lock_flag = 1'b0;
		polls_if.hold_flag = 1'b0;
		polls_if.count_enable = 1'b0;
		sender_idle = 1'b1;
		sink_idle = 1'b1;
		stall_go = 1'b0;
		stamp = '0;
		lk_cur = 1'b1;
		hd_cur = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Merge time still at its reset value of zero: a drop across the time
		// wrap that closes at once when lock returns at time zero.
		send_word(ACT_INIT, 64'hFFFF_FFFF_FFFF_FFEC, 1'b1, 1'b0, 1'b0);
		send_word(ACT_POLL, 64'hFFFF_FFFF_FFFF_FFF6, 1'b0, 1'b0, 1'b1);
		send_word(ACT_POLL, 64'd0, 1'b1, 1'b0, 1'b1);
		send_word(ACT_POLL, 64'd5, 1'b0, 1'b0, 1'b0);
		send_word(ACT_POLL, 64'd6, 1'b1, 1'b0, 1'b0);
		send_word(ACT_INIT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1);
		send_word(ACT_POLL, 64'd7, 1'b1, 1'b1, 1'b1);
		send_word(ACT_POLL, 64'd8, 1'b0, 1'b1, 1'b1);
		send_word(ACT_POLL, 64'd9, 1'b1, 1'b0, 1'b1);
		set_merge(64'd50);
		send_word(ACT_POLL, 64'd10, 1'b0, 1'b0, 1'b1);
		send_word(ACT_POLL, 64'd20, 1'b1, 1'b0, 1'b1);
		send_word(ACT_POLL, 64'd30, 1'b0, 1'b0, 1'b1);
		send_word(ACT_POLL, 64'd40, 1'b1, 1'b0, 1'b1);
		send_word(ACT_POLL, 64'd60, 1'b1, 1'b0, 1'b1);
		send_word(ACT_POLL, 64'd90, 1'b1, 1'b0, 1'b1);
		send_word(ACT_POLL, 64'd100, 1'b0, 1'b0, 1'b1);
		send_word(ACT_POLL, 64'd110, 1'b0, 1'b1, 1'b1);
		send_word(ACT_POLL, 64'd120, 1'b1, 1'b0, 1'b1);
		send_word(ACT_INIT, 64'd0, 1'b1, 1'b0, 1'b1);
		send_word(ACT_POLL, 64'd0, 1'b0, 1'b0, 1'b1);
		send_word(ACT_POLL, 64'd0, 1'b1, 1'b0, 1'b1);
		send_word(ACT_POLL, 64'd50, 1'b1, 1'b0, 1'b1);
		send_word(ACT_POLL, 64'h8000_0000_0000_0000, 1'b1, 1'b1, 1'b0);

		set_merge(64'd1);
		random_run(250, 4, -1);
		set_merge(64'd0);
		random_run(200, 10, -1);
		set_merge(64'hFFFF_FFFF_FFFF_FFFF);
		random_run(200, 1000, -1);

		// Back to back on both sides, with the receiver held off for a while.
		sender_idle = 1'b0;
		sink_idle = 1'b0;
		set_merge(64'd40);
		random_run(300, 40, 50);
		sender_idle = 1'b1;
		sink_idle = 1'b1;

		set_merge({$urandom, $urandom});
		random_run(150, 1000, -1);
		set_merge(64'($urandom_range(2, 200)));
		random_run(250, 100, -1);

		polls_if.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("Checked %0d report words, %0d of them closing a drop, under 7 merge times.",
			word_count, event_count);
		$display("Random gaps on both channels, one %0d-cycle receiver hold-off.", LONG_HOLD);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- lock_drop_monitor.f -----
src/ldm_pkg.sv
src/ldm_if.sv
src/ldm_cfg_regs.sv
src/ldm_core.sv
src/lock_drop_monitor.sv
tb/sv/ldm_report_checker.sv
tb/sv/tb.sv
